### sv/pcdd_pkg.sv
package pcdd_pkg;

    // Datapath widths (Q16.16)
    localparam int DATA_W    = 32;
    localparam int LIM_W     = 31;
    localparam int FRAC_W    = 16;
    localparam int DIFF_W    = DATA_W + 1;            // ref - fdb, fdb - last_fdb
    localparam int PROD_W    = DATA_W + DIFF_W;       // full gain * difference
    localparam int TERM_W    = PROD_W - FRAC_W;       // product after dropping fraction
    localparam int SUM_W     = TERM_W + 2;            // p + i + d, no wrap
    localparam int CFG_IDX_W = 3;

    // Configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN      = 3'd0,
        CFG_INTEG_GAIN     = 3'd1,
        CFG_DERIV_GAIN     = 3'd2,
        CFG_OUTPUT_LIMIT   = 3'd3,
        CFG_INTEGRAL_LIMIT = 3'd4,
        CFG_VELOCITY_MODE  = 3'd5
    } cfg_idx_t;

    // Item function codes
    localparam logic FUNC_STEP  = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    // Symmetric clamp of a wide signed sum to +/- lim
    function automatic logic signed [DATA_W-1:0] clamp_sym(
        input logic signed [SUM_W-1:0] v,
        input logic        [LIM_W-1:0] lim
    );
        logic signed [SUM_W-1:0]  lim_wide;
        logic signed [DATA_W-1:0] lim_pos;
        lim_wide = signed'({{(SUM_W-LIM_W){1'b0}}, lim});
        lim_pos  = signed'({1'b0, lim});
        if (v > lim_wide) begin
            return lim_pos;
        end else if (v < -lim_wide) begin
            return -lim_pos;
        end else begin
            return v[DATA_W-1:0];
        end
    endfunction

endpackage

### sv/pid_clamped_dual_derivative.sv
// Channel   Direction  Signals                                         Beat
// s_        in         s_valid/s_ready, func, reference, feedback,      one item
//                      velocity
// m_        out        m_valid/m_ready, drive, integral_value           one result
// cfg_      in         cfg_valid/cfg_ready, cfg_index, cfg_data         one register write
//
// m_valid rises once the s_ beat has passed the input register, then the result register.
// One item per cycle sustained while m_ready stays high; the integral update loop sets that figure.
// aresetn (synchronous, active low) clears both valid stages, the integral, last feedback and config registers.
// A stalled result holds in the result register while one more item waits in the input
// register; s_ready drops only when both are full and m_ready is low.
module pid_clamped_dual_derivative (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // configuration writes
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [pcdd_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [pcdd_pkg::DATA_W-1:0]             cfg_data,
    // input items
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic                                    s_func,
    input  logic signed [pcdd_pkg::DATA_W-1:0]      s_reference,
    input  logic signed [pcdd_pkg::DATA_W-1:0]      s_feedback,
    input  logic signed [pcdd_pkg::DATA_W-1:0]      s_velocity,
    // results
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [pcdd_pkg::DATA_W-1:0]      m_drive,
    output logic signed [pcdd_pkg::DATA_W-1:0]      m_integral_value
);
    import pcdd_pkg::*;

    // configuration registers
    logic signed [DATA_W-1:0] prop_gain_reg;
    logic signed [DATA_W-1:0] integ_gain_reg;
    logic signed [DATA_W-1:0] deriv_gain_reg;
    logic        [LIM_W-1:0]  output_limit_reg;
    logic        [LIM_W-1:0]  integral_limit_reg;
    logic                     velocity_mode_reg;

    // input stage
    logic                     in_valid_reg;
    logic                     in_func_reg;
    logic signed [DATA_W-1:0] in_ref_reg;
    logic signed [DATA_W-1:0] in_fdb_reg;
    logic signed [DATA_W-1:0] in_vel_reg;

    // controller state
    logic signed [DATA_W-1:0] integral_acc_reg;
    logic signed [DATA_W-1:0] integral_acc_next;
    logic signed [DATA_W-1:0] prev_fdb_reg;
    logic signed [DATA_W-1:0] prev_fdb_next;

    // result stage
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] out_drive_reg;
    logic signed [DATA_W-1:0] out_drive_next;
    logic signed [DATA_W-1:0] out_integ_reg;

    // datapath
    logic                     out_free;
    logic                     advance;
    logic signed [DIFF_W-1:0] err;
    logic signed [DIFF_W-1:0] d_operand;
    logic signed [PROD_W-1:0] p_prod;
    logic signed [PROD_W-1:0] i_prod;
    logic signed [PROD_W-1:0] d_prod;
    logic signed [TERM_W-1:0] p_term;
    logic signed [TERM_W-1:0] i_term;
    logic signed [TERM_W-1:0] d_term;
    logic signed [SUM_W-1:0]  integ_sum;
    logic signed [SUM_W-1:0]  drive_sum;

    // handshake
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_ready;
    assign advance   = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;

    assign m_valid          = out_valid_reg;
    assign m_drive          = out_drive_reg;
    assign m_integral_value = out_integ_reg;

    // configuration write decode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg      <= '0;
            integ_gain_reg     <= '0;
            deriv_gain_reg     <= '0;
            output_limit_reg   <= '0;
            integral_limit_reg <= '0;
            velocity_mode_reg  <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_PROP_GAIN:      prop_gain_reg      <= cfg_data;
                CFG_INTEG_GAIN:     integ_gain_reg     <= cfg_data;
                CFG_DERIV_GAIN:     deriv_gain_reg     <= cfg_data;
                CFG_OUTPUT_LIMIT:   output_limit_reg   <= cfg_data[LIM_W-1:0];
                CFG_INTEGRAL_LIMIT: integral_limit_reg <= cfg_data[LIM_W-1:0];
                CFG_VELOCITY_MODE:  velocity_mode_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_func_reg <= s_func;
            in_ref_reg  <= s_reference;
            in_fdb_reg  <= s_feedback;
            in_vel_reg  <= s_velocity;
        end
    end

    // error and derivative operand, 33 bits exact
    assign err = DIFF_W'(in_ref_reg) - DIFF_W'(in_fdb_reg);
    always_comb begin
        if (velocity_mode_reg) begin
            d_operand = DIFF_W'(in_vel_reg);
        end else begin
            d_operand = DIFF_W'(in_fdb_reg) - DIFF_W'(prev_fdb_reg);
        end
    end

    // three gain products; dropping the low bits truncates toward minus infinity
    assign p_prod = PROD_W'(prop_gain_reg)  * PROD_W'(err);
    assign i_prod = PROD_W'(integ_gain_reg) * PROD_W'(err);
    assign d_prod = PROD_W'(deriv_gain_reg) * PROD_W'(d_operand);
    assign p_term = p_prod[PROD_W-1:FRAC_W];
    assign i_term = i_prod[PROD_W-1:FRAC_W];
    assign d_term = d_prod[PROD_W-1:FRAC_W];

    // integral update and drive, each clamped; a clear item zeroes both and the last feedback
    always_comb begin
        integ_sum = SUM_W'(integral_acc_reg) + SUM_W'(i_term);
        if (in_func_reg == FUNC_CLEAR) begin
            integral_acc_next = '0;
            prev_fdb_next     = '0;
            drive_sum         = '0;
            out_drive_next    = '0;
        end else begin
            integral_acc_next = clamp_sym(integ_sum, integral_limit_reg);
            prev_fdb_next     = in_fdb_reg;
            drive_sum         = SUM_W'(p_term) + SUM_W'(integral_acc_next) + SUM_W'(d_term);
            out_drive_next    = clamp_sym(drive_sum, output_limit_reg);
        end
    end

    // controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integral_acc_reg <= '0;
            prev_fdb_reg     <= '0;
        end else if (advance) begin
            integral_acc_reg <= integral_acc_next;
            prev_fdb_reg     <= prev_fdb_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_drive_reg <= out_drive_next;
            out_integ_reg <= integral_acc_next;
        end
    end

endmodule

### sv/pcdd_checker.sv
module pcdd_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                cfg_valid,
    input logic                                cfg_ready,
    input logic [pcdd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input logic [pcdd_pkg::DATA_W-1:0]         cfg_data,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [pcdd_pkg::DATA_W-1:0]  m_drive,
    input logic signed [pcdd_pkg::DATA_W-1:0]  m_integral_value
);
    import pcdd_pkg::*;

    // shadow copies of the two limits, seen from the config port
    logic signed [DATA_W-1:0] out_lim_reg;
    logic signed [DATA_W-1:0] int_lim_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_lim_reg <= '0;
            int_lim_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_OUTPUT_LIMIT) begin
                out_lim_reg <= signed'({1'b0, cfg_data[LIM_W-1:0]});
            end
            if (cfg_index == CFG_INTEGRAL_LIMIT) begin
                int_lim_reg <= signed'({1'b0, cfg_data[LIM_W-1:0]});
            end
        end
    end

    // reset empties the result side
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result beat holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_drive) && $stable(m_integral_value))
        else $error("stalled result changed");

    // drive stays within the programmed output limit
    a_drive_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_drive <= out_lim_reg) && (m_drive >= -out_lim_reg))
        else $error("drive outside output limit");

    // integral stays within the programmed integral limit
    a_integ_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_integral_value <= int_lim_reg) && (m_integral_value >= -int_lim_reg))
        else $error("integral outside integral limit");

endmodule

bind pid_clamped_dual_derivative pcdd_checker u_pcdd_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_drive          (m_drive),
    .m_integral_value (m_integral_value)
);

### bench/pid_clamped_dual_derivative_checker.sv
// Watches the config, item and result channels of the PID block, predicts each result and
// compares it with what comes out.
module pid_clamped_dual_derivative_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [pcdd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pcdd_pkg::DATA_W-1:0]         cfg_data,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic                                s_func,
    input  logic signed [pcdd_pkg::DATA_W-1:0]  s_reference,
    input  logic signed [pcdd_pkg::DATA_W-1:0]  s_feedback,
    input  logic signed [pcdd_pkg::DATA_W-1:0]  s_velocity,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [pcdd_pkg::DATA_W-1:0]  m_drive,
    input  logic signed [pcdd_pkg::DATA_W-1:0]  m_integral_value,
    output int                                  mismatches,
    output int                                  results_due,
    output int                                  results_checked
);
    import pcdd_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] drive;
        logic signed [DATA_W-1:0] integral;
    } pid_result_t;

    // shadow registers, held wide and already sign- or zero-extended
    longint      kp, ki, kd, drive_lim, integ_lim;
    logic        vel_mode;

    // controller state
    longint      integ_acc, last_fdb;

    pid_result_t pid_outputs_due[$];
    int          fail_tally;
    int          checked_tally;

    initial begin
        mismatches      = 0;
        results_due     = 0;
        results_checked = 0;
        fail_tally      = 0;
        checked_tally   = 0;
    end

    // gain * x in Q16.16, low bits dropped (floor)
    function automatic longint q16_product(longint gain, longint x);
        longint p;
        p = gain * x;
        return p >>> FRAC_W;
    endfunction

    function automatic longint clamp_to(longint v, longint lim);
        if (v > lim) begin
            return lim;
        end else if (v < -lim) begin
            return -lim;
        end
        return v;
    endfunction

    // one controller step; updates the integral and last feedback
    function automatic pid_result_t pid_advance(logic func, logic signed [DATA_W-1:0] r,
                                                logic signed [DATA_W-1:0] f,
                                                logic signed [DATA_W-1:0] v);
        longint      err, p_term, d_term;
        pid_result_t res;
        if (func == FUNC_CLEAR) begin
            integ_acc    = 0;
            last_fdb     = 0;
            res.drive    = '0;
            res.integral = '0;
            return res;
        end
        err    = longint'(r) - longint'(f);
        p_term = q16_product(kp, err);
        d_term = vel_mode ? q16_product(kd, longint'(v))
                          : q16_product(kd, longint'(f) - last_fdb);
        integ_acc    = clamp_to(integ_acc + q16_product(ki, err), integ_lim);
        res.drive    = DATA_W'(clamp_to(p_term + integ_acc + d_term, drive_lim));
        res.integral = DATA_W'(integ_acc);
        last_fdb     = longint'(f);
        return res;
    endfunction

    function automatic int field_differs(string name, logic signed [DATA_W-1:0] want,
                                         logic signed [DATA_W-1:0] got);
        if (want === got) begin
            return 0;
        end
        $display("%0t: %s mismatch, expected %0d (%h), actual %0d (%h)",
                 $time, name, want, want, got, got);
        return 1;
    endfunction

    always @(posedge aclk) begin
        pid_result_t want;
        if (!aresetn) begin
            kp        = 0;
            ki        = 0;
            kd        = 0;
            drive_lim = 0;
            integ_lim = 0;
            vel_mode  = 1'b0;
            integ_acc = 0;
            last_fdb  = 0;
            pid_outputs_due.delete();
        end else begin
            // result beat: compare against the oldest prediction
            if (m_valid && m_ready) begin
                if (pid_outputs_due.size() == 0) begin
                    $display("%0t: result with nothing expected, drive %0d integral %0d",
                             $time, m_drive, m_integral_value);
                    fail_tally++;
                end else begin
                    want = pid_outputs_due.pop_front();
                    fail_tally += field_differs("drive", want.drive, m_drive);
                    fail_tally += field_differs("integral_value", want.integral,
                                                m_integral_value);
                    checked_tally++;
                end
            end

            // register write beat
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_PROP_GAIN:      kp        = longint'(signed'(cfg_data));
                    CFG_INTEG_GAIN:     ki        = longint'(signed'(cfg_data));
                    CFG_DERIV_GAIN:     kd        = longint'(signed'(cfg_data));
                    CFG_OUTPUT_LIMIT:   drive_lim = longint'(cfg_data[LIM_W-1:0]);
                    CFG_INTEGRAL_LIMIT: integ_lim = longint'(cfg_data[LIM_W-1:0]);
                    CFG_VELOCITY_MODE:  vel_mode  = cfg_data[0];
                    default: ;
                endcase
            end

            // item beat: predict its result
            if (s_valid && s_ready) begin
                pid_outputs_due.push_back(pid_advance(s_func, s_reference, s_feedback,
                                                      s_velocity));
            end
        end
        mismatches      <= fail_tally;
        results_due     <= pid_outputs_due.size();
        results_checked <= checked_tally;
    end

endmodule

### bench/tb_pid_clamped_dual_derivative.sv
module tb_pid_clamped_dual_derivative;
    import pcdd_pkg::*;

    localparam int STALL_LIMIT = 2000;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;

    // indexes past the register map; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

    logic                        aclk;
    logic                        aresetn;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [DATA_W-1:0]           cfg_data;
    logic                        s_valid;
    logic                        s_ready;
    logic                        s_func;
    logic signed [DATA_W-1:0]    s_reference;
    logic signed [DATA_W-1:0]    s_feedback;
    logic signed [DATA_W-1:0]    s_velocity;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic signed [DATA_W-1:0]    m_drive;
    logic signed [DATA_W-1:0]    m_integral_value;

    int mismatch_total;
    int results_due;
    int results_checked;

    int send_idle_pct = 28;
    int recv_idle_pct = 59;
    int items_sent;
    int clears_sent;
    int settings_loaded;
    int idle_cycles;

    pid_clamped_dual_derivative DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_reference      (s_reference),
        .s_feedback       (s_feedback),
        .s_velocity       (s_velocity),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_drive          (m_drive),
        .m_integral_value (m_integral_value)
    );

    pid_clamped_dual_derivative_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_reference      (s_reference),
        .s_feedback       (s_feedback),
        .s_velocity       (s_velocity),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_drive          (m_drive),
        .m_integral_value (m_integral_value),
        .mismatches       (mismatch_total),
        .results_due      (results_due),
        .results_checked  (results_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // cycles since the last beat on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        idle_cycles = 0;
        @(posedge aclk);
        while (idle_cycles < STALL_LIMIT) @(posedge aclk);
        $display("%0t: no beat for %0d cycles, %0d results still due",
                 $time, STALL_LIMIT, results_due);
        $display("[FAIL] regression broken");
        $finish;
    end

    // mostly small magnitudes so the loop does real work, plus extremes and raw noise
    function automatic logic signed [DATA_W-1:0] rand_value();
        case ($urandom_range(9))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3, 4:    return $urandom;
            default: return 32'($urandom_range(32'h0040_0000)) - 32'h0020_0000;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_gain();
        case ($urandom_range(9))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3:       return $urandom;
            default: return 32'($urandom_range(32'h0010_0000)) - 32'h0008_0000;
        endcase
    endfunction

    // raw draws carry bit 31 too, which the block must drop
    function automatic logic [DATA_W-1:0] rand_limit();
        case ($urandom_range(7))
            0:       return '0;
            1:       return 32'h7FFF_FFFF;
            2:       return $urandom;
            default: return 32'($urandom_range(32'h0200_0000));
        endcase
    endfunction

    // one item beat; valid stays up across back-to-back items
    task automatic push_item(input logic func, input logic signed [DATA_W-1:0] r,
                             input logic signed [DATA_W-1:0] f,
                             input logic signed [DATA_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_func      <= func;
        s_reference <= r;
        s_feedback  <= f;
        s_velocity  <= v;
        items_sent++;
        if (func == FUNC_CLEAR) begin
            clears_sent++;
        end
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop sending and wait for every predicted result to come out
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_due != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // full register set, written only with the block idle
    task automatic load_settings(input logic [DATA_W-1:0] kp, input logic [DATA_W-1:0] ki,
                                 input logic [DATA_W-1:0] kd, input logic [DATA_W-1:0] olim,
                                 input logic [DATA_W-1:0] ilim, input logic [DATA_W-1:0] vmode);
        drain();
        write_reg(CFG_PROP_GAIN, kp);
        write_reg(CFG_UNMAPPED_LO, $urandom);
        write_reg(CFG_INTEG_GAIN, ki);
        write_reg(CFG_DERIV_GAIN, kd);
        write_reg(CFG_OUTPUT_LIMIT, olim);
        write_reg(CFG_INTEGRAL_LIMIT, ilim);
        write_reg(CFG_UNMAPPED_HI, $urandom);
        write_reg(CFG_VELOCITY_MODE, vmode);
        cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    // random settings, then a stream of steps with occasional clears
    task automatic random_run(input int count);
        load_settings(rand_gain(), rand_gain(), rand_gain(), rand_limit(), rand_limit(),
                      $urandom);
        for (int i = 0; i < count; i++) begin
            // hold off mid-run until the pipeline is empty
            if (i == count / 2) begin
                drain();
            end
            push_item(($urandom_range(19) == 0) ? FUNC_CLEAR : FUNC_STEP,
                      rand_value(), rand_value(), rand_value());
        end
    endtask

    initial begin
        aresetn         = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        s_valid         = 1'b0;
        s_func          = FUNC_STEP;
        s_reference     = '0;
        s_feedback      = '0;
        s_velocity      = '0;
        items_sent      = 0;
        clears_sent     = 0;
        settings_loaded = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset register values: every gain and limit is zero
        push_item(FUNC_STEP, Q_MAX, Q_MIN, Q_MAX);
        push_item(FUNC_STEP, Q_ONE, 0, -1);

        // kp of one, ki and kd below one; output limit has its ignored top bit set
        load_settings(Q_ONE, 32'h0000_4000, 32'h0000_8000, 32'hFFFF_FFFF, 32'h0064_0000,
                      32'h0);
        push_item(FUNC_STEP, Q_MAX, Q_MIN, Q_MIN);
        push_item(FUNC_STEP, Q_MIN, Q_MAX, Q_MAX);
        push_item(FUNC_STEP, -1, 0, 0);
        push_item(FUNC_STEP, 0, -1, 0);
        push_item(FUNC_CLEAR, Q_MAX, Q_MIN, Q_MAX);
        repeat (3) push_item(FUNC_STEP, Q_ONE, 0, 0);

        // extreme gains, full limits, velocity mode via a value with high bits set
        load_settings(Q_MAX, Q_MIN, Q_MIN, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        push_item(FUNC_STEP, Q_MAX, Q_MIN, Q_MAX);
        push_item(FUNC_STEP, Q_MIN, Q_MAX, Q_MIN);
        push_item(FUNC_STEP, Q_MIN, Q_MIN, Q_MIN);
        push_item(FUNC_CLEAR, 0, 0, 0);
        push_item(FUNC_STEP, 0, Q_MAX, -1);

        // both limits zero once the ignored top bit is dropped
        load_settings(Q_MIN, Q_MAX, Q_MAX, 32'h8000_0000, 32'h8000_0000, 32'h2);
        push_item(FUNC_STEP, Q_MAX, Q_MIN, Q_MAX);
        push_item(FUNC_STEP, 32'sd12345, -32'sd6789, 32'sd1);

        // random part: three pacing phases, four settings each
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 28;
                    recv_idle_pct = 59;
                end
                1: begin
                    send_idle_pct = 59;
                    recv_idle_pct = 28;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            repeat (4) random_run(155);
        end

        drain();
        repeat (8) @(posedge aclk);
        $display("covered %0d items (%0d clears) under %0d register settings, %0d results checked",
                 items_sent, clears_sent, settings_loaded, results_checked);
        $display("pacing: sender and receiver stalls both ways round, then full rate");
        if (mismatch_total == 0 && results_due == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### sim.f
sv/pcdd_pkg.sv
sv/pid_clamped_dual_derivative.sv
sv/pcdd_checker.sv
bench/pid_clamped_dual_derivative_checker.sv
bench/tb_pid_clamped_dual_derivative.sv
